// File: hdl/lmd_pkg.sv
// Shared constants, payload types and state encoding for the local maxima detector.
package lmd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_RADIUS  = 8;
  localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW          = $clog2(STORE_DEPTH);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic MODE_PIXEL = 1'b0;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic       is_peak;
    logic [9:0] peak_row;
    logic [9:0] peak_col;
    logic       frame_last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WAIT
  } state_e;

endpackage

// File: hdl/lmd_store.sv
// Circular pixel line store: one write port, one read port with registered data.
module lmd_store (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [lmd_pkg::AW-1:0]  waddr_i,
  input  logic [31:0]             wdata_i,
  input  logic                    re_i,
  input  logic [lmd_pkg::AW-1:0]  raddr_i,
  output logic [31:0]             rdata_o
);

  logic [31:0] mem [lmd_pkg::STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hdl/window_local_maxima_detector_core.sv
// Top level: raster-order square-window local maxima detector.
// An item that completes a window passes through ST_CHECK, ST_SCAN and ST_WAIT before its word
// is registered; the store read port reads one pixel a cycle over the clipped rows by cols window.
// Throughput: one item at a time, with in_stall_o high while an item is checked and scanned,
// and longer while the previous word waits on out_stall_i.
// Reset clears positions, addresses, control state and restores the default configuration.
module window_local_maxima_detector_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lmd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lmd_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [10:0]        cfg_data_i
);

  localparam int AW = lmd_pkg::AW;
  localparam logic [AW:0] DEPTH = (AW+1)'(lmd_pkg::STORE_DEPTH);

  lmd_pkg::state_e state_q, state_d;

  logic [10:0] cfg_w_q, cfg_h_q;
  logic [3:0]  cfg_r_q;
  logic [10:0] w, h;
  logic [3:0]  r;

  logic [10:0]   in_row_q;
  logic [9:0]    in_col_q, out_row_q, out_col_q;
  logic [AW-1:0] wr_addr_q, out_addr_q;

  // scan registers
  logic [3:0]    dr_q, dc_q;
  logic [4:0]    nrows_q, ncols_q, si_q, sj_q;
  logic [AW-1:0] row_addr_q, cur_addr_q;
  logic          rd_vld_q, rd_first_q, rd_centre_q, rd_last_q;
  logic signed [31:0] mx_q, cent_q;
  logic [31:0]   rdata;

  lmd_pkg::out_word_t out_q;
  logic               out_valid_q;

  // effective configuration
  always_comb begin
    w = (cfg_w_q == 11'd0) ? 11'd1 :
        (cfg_w_q > 11'(lmd_pkg::MAX_WIDTH)) ? 11'(lmd_pkg::MAX_WIDTH) : cfg_w_q;
    h = (cfg_h_q == 11'd0) ? 11'd1 :
        (cfg_h_q > 11'(lmd_pkg::MAX_HEIGHT)) ? 11'(lmd_pkg::MAX_HEIGHT) : cfg_h_q;
    r = (cfg_r_q > 4'(lmd_pkg::MAX_RADIUS)) ? 4'(lmd_pkg::MAX_RADIUS) : cfg_r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 11'(lmd_pkg::MAX_WIDTH);
      cfg_h_q <= 11'(lmd_pkg::MAX_HEIGHT);
      cfg_r_q <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lmd_pkg::REG_WIDTH:  cfg_w_q <= cfg_data_i;
        lmd_pkg::REG_HEIGHT: cfg_h_q <= cfg_data_i;
        lmd_pkg::REG_RADIUS: cfg_r_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input step
  logic          accept, restart, wr_en, in_done1;
  logic [10:0]   ir0, ir1, ir2, ic0, ic1, ic2;
  logic [AW-1:0] wa0, wa_next;

  assign accept = in_valid_i && (state_q == lmd_pkg::ST_IDLE);

  always_comb begin
    restart = (11'(out_row_q) >= h) || (11'(out_col_q) >= w);
    ir0 = restart ? 11'd0 : in_row_q;
    ic0 = restart ? 11'd0 : 11'(in_col_q);
    wa0 = restart ? '0 : wr_addr_q;
    if (ic0 >= w) begin
      ic1 = 11'd0;
      ir1 = ir0 + 11'd1;
    end else begin
      ic1 = ic0;
      ir1 = ir0;
    end
    in_done1 = ir1 >= h;
    wr_en = accept && (in_word_i.mode == lmd_pkg::MODE_PIXEL) && !in_done1;
    ic2 = ic1;
    ir2 = ir1;
    wa_next = wa0;
    if (wr_en) begin
      ic2 = ic1 + 11'd1;
      if (ic2 >= w) begin
        ic2 = 11'd0;
        ir2 = ir1 + 11'd1;
      end
      wa_next = ({1'b0, wa0} + 1'b1 == DEPTH) ? '0 : wa0 + 1'b1;
    end
  end

  // window check
  logic [10:0]   rhi, chi, rsum, csum;
  logic [3:0]    dr, dc;
  logic          ready, slot_free;
  logic [14:0]   off;
  logic [AW:0]   start;

  always_comb begin
    rsum = 11'(out_row_q) + 11'(r);
    csum = 11'(out_col_q) + 11'(r);
    rhi = (rsum > h - 11'd1) ? h - 11'd1 : rsum;
    chi = (csum > w - 11'd1) ? w - 11'd1 : csum;
    ready = (in_row_q >= h) || (rhi < in_row_q) ||
            ((rhi == in_row_q) && (chi < 11'(in_col_q)));
    dr = (out_row_q >= 10'(r)) ? r : out_row_q[3:0];
    dc = (out_col_q >= 10'(r)) ? r : out_col_q[3:0];
    off = 15'(dr) * 15'(w) + 15'(dc);
    start = ({1'b0, out_addr_q} >= (AW+1)'(off)) ?
            {1'b0, out_addr_q} - (AW+1)'(off) :
            {1'b0, out_addr_q} + DEPTH - (AW+1)'(off);
    slot_free = !out_valid_q || !out_stall_i;
  end

  // scan step
  logic          s_first, s_centre, s_last, row_end;
  logic [AW:0]   nxt_row, nxt_col;

  always_comb begin
    s_first  = (si_q == 5'd0) && (sj_q == 5'd0);
    s_centre = (si_q == 5'(dr_q)) && (sj_q == 5'(dc_q));
    row_end  = (sj_q == ncols_q);
    s_last   = (si_q == nrows_q) && row_end;
    nxt_row  = {1'b0, row_addr_q} + (AW+1)'(w);
    if (nxt_row >= DEPTH) nxt_row = nxt_row - DEPTH;
    nxt_col  = {1'b0, cur_addr_q} + 1'b1;
    if (nxt_col == DEPTH) nxt_col = '0;
  end

  // final decision on last read word
  logic signed [31:0] rd_s, mx_fin, cent_fin;
  logic               finish, last_px;

  always_comb begin
    rd_s     = $signed(rdata);
    mx_fin   = (rd_first_q || rd_s > mx_q) ? rd_s : mx_q;
    cent_fin = rd_centre_q ? rd_s : cent_q;
    finish   = rd_vld_q && rd_last_q;
    last_px  = (11'(out_row_q) == h - 11'd1) && (11'(out_col_q) == w - 11'd1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lmd_pkg::ST_IDLE:  if (accept) state_d = lmd_pkg::ST_CHECK;
      lmd_pkg::ST_CHECK: begin
        if (!ready) state_d = lmd_pkg::ST_IDLE;
        else if (slot_free) state_d = lmd_pkg::ST_SCAN;
      end
      lmd_pkg::ST_SCAN:  if (s_last) state_d = lmd_pkg::ST_WAIT;
      lmd_pkg::ST_WAIT:  if (finish) state_d = lmd_pkg::ST_IDLE;
      default:           state_d = lmd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      wr_addr_q   <= '0;
      out_addr_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == lmd_pkg::ST_SCAN);
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (accept) begin
        in_row_q  <= ir2;
        in_col_q  <= ic2[9:0];
        wr_addr_q <= wa_next;
        if (restart) begin
          out_row_q  <= '0;
          out_col_q  <= '0;
          out_addr_q <= '0;
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        if (last_px) begin
          in_row_q   <= '0;
          in_col_q   <= '0;
          out_row_q  <= '0;
          out_col_q  <= '0;
          wr_addr_q  <= '0;
          out_addr_q <= '0;
        end else begin
          out_addr_q <= ({1'b0, out_addr_q} + 1'b1 == DEPTH) ? '0 : out_addr_q + 1'b1;
          if (11'(out_col_q) + 11'd1 >= w) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 10'd1;
          end else begin
            out_col_q <= out_col_q + 10'd1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == lmd_pkg::ST_CHECK) begin
      dr_q       <= dr;
      dc_q       <= dc;
      nrows_q    <= 5'(rhi - (11'(out_row_q) - 11'(dr)));
      ncols_q    <= 5'(chi - (11'(out_col_q) - 11'(dc)));
      si_q       <= '0;
      sj_q       <= '0;
      row_addr_q <= start[AW-1:0];
      cur_addr_q <= start[AW-1:0];
    end else if (state_q == lmd_pkg::ST_SCAN) begin
      if (row_end) begin
        sj_q       <= '0;
        si_q       <= si_q + 5'd1;
        row_addr_q <= nxt_row[AW-1:0];
        cur_addr_q <= nxt_row[AW-1:0];
      end else begin
        sj_q       <= sj_q + 5'd1;
        cur_addr_q <= nxt_col[AW-1:0];
      end
    end
    rd_first_q  <= s_first;
    rd_centre_q <= s_centre;
    rd_last_q   <= s_last;
    if (rd_vld_q) begin
      mx_q   <= mx_fin;
      cent_q <= cent_fin;
    end
    if (finish) begin
      out_q.is_peak    <= (cent_fin == mx_fin);
      out_q.peak_row   <= out_row_q;
      out_q.peak_col   <= out_col_q;
      out_q.frame_last <= last_px;
    end
  end

  lmd_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wa0),
    .wdata_i (in_word_i.pixel_value),
    .re_i    (state_q == lmd_pkg::ST_SCAN),
    .raddr_i (cur_addr_q),
    .rdata_o (rdata)
  );

  assign in_stall_o  = (state_q != lmd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
